[hdl/sve_pkg.sv]
package sve_pkg;

	localparam int COORD_W   = 32;
	localparam int NORM_W    = 16;
	localparam int VIDX_W    = 12;
	localparam int SLOT_W    = 13;
	localparam int MASK_W    = 3;
	localparam int REG_IDX_W = 3;
	localparam int PROD_W    = NORM_W + COORD_W;
	localparam int DOT_W     = PROD_W + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic [VIDX_W-1:0]         vidx_t;
	typedef logic [SLOT_W-1:0]         slot_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FAR_X,
		REG_FAR_Y,
		REG_FAR_Z,
		REG_NEAR_X,
		REG_NEAR_Y,
		REG_NEAR_Z,
		REG_VERTEX_COUNT
	} reg_idx_t;

	// one item as handed to the result sequencer
	typedef struct packed {
		logic              is_vtx;
		logic              front;
		logic [MASK_W-1:0] open_mask;
		vidx_t             vidx;
		slot_t             slot_far;
		coord_t            near_x;
		coord_t            near_y;
		coord_t            near_z;
		coord_t            far_x;
		coord_t            far_y;
		coord_t            far_z;
		vidx_t             p0;
		vidx_t             p1;
		vidx_t             p2;
		slot_t             q0;
		slot_t             q1;
		slot_t             q2;
	} item_t;

endpackage

[hdl/sve_item_if.sv]
interface sve_item_if import sve_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	vidx_t             vertex_index;
	coord_t            pos_x;
	coord_t            pos_y;
	coord_t            pos_z;
	vidx_t             corner_0;
	vidx_t             corner_1;
	vidx_t             corner_2;
	norm_t             normal_x;
	norm_t             normal_y;
	norm_t             normal_z;
	logic [MASK_W-1:0] open_mask;

	modport source (
		output valid, action, vertex_index, pos_x, pos_y, pos_z,
			corner_0, corner_1, corner_2, normal_x, normal_y, normal_z, open_mask,
		input ready
	);
	modport sink (
		input valid, action, vertex_index, pos_x, pos_y, pos_z,
			corner_0, corner_1, corner_2, normal_x, normal_y, normal_z, open_mask,
		output ready
	);
endinterface

[hdl/sve_result_if.sv]
interface sve_result_if import sve_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   is_vertex;
	slot_t  slot;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	slot_t  tri_a;
	slot_t  tri_b;
	slot_t  tri_c;
	logic   last;

	modport source (
		output valid, is_vertex, slot, out_x, out_y, out_z, tri_a, tri_b, tri_c, last,
		input ready
	);
	modport sink (
		input valid, is_vertex, slot, out_x, out_y, out_z, tri_a, tri_b, tri_c, last,
		output ready
	);
endinterface

[hdl/sve_emit.sv]
module sve_emit import sve_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load_valid,
	output logic  load_ready,
	input  item_t load_item,
	sve_result_if.source result
);

	logic       busy_q;
	item_t      it_q;
	logic [2:0] step_q;

	logic       out_free;
	logic       fire;
	logic       at_last;
	logic [1:0] open_cnt;
	logic [2:0] last_idx;
	logic [1:0] side;
	logic [1:0] first_edge;
	logic [1:0] second_edge;
	logic [1:0] edge_sel;
	slot_t      pa, pb, qa, qb;
	slot_t      ta, tb, tc;
	slot_t      p0, p1, p2;

	logic   valid_q;
	logic   is_vertex_q;
	slot_t  slot_q;
	coord_t out_x_q;
	coord_t out_y_q;
	coord_t out_z_q;
	slot_t  tri_a_q;
	slot_t  tri_b_q;
	slot_t  tri_c_q;
	logic   last_q;

	assign out_free = !valid_q || result.ready;
	assign fire     = busy_q && out_free;

	assign open_cnt = 2'(it_q.open_mask[0]) + 2'(it_q.open_mask[1]) + 2'(it_q.open_mask[2]);
	// two caps, then two triangles for each open edge
	assign last_idx = it_q.is_vtx ? 3'd1 : {open_cnt, 1'b1};
	assign at_last  = (step_q == last_idx);

	assign load_ready = !busy_q || (fire && at_last);

	assign p0 = SLOT_W'(it_q.p0);
	assign p1 = SLOT_W'(it_q.p1);
	assign p2 = SLOT_W'(it_q.p2);

	// pick the open edge that this side pair belongs to, lowest edge first
	always_comb begin
		side        = step_q[2:1] - 2'd1;
		first_edge  = it_q.open_mask[0] ? 2'd0 : (it_q.open_mask[1] ? 2'd1 : 2'd2);
		second_edge = (it_q.open_mask[0] && it_q.open_mask[1]) ? 2'd1 : 2'd2;
		case (side)
			2'd0:    edge_sel = first_edge;
			2'd1:    edge_sel = second_edge;
			default: edge_sel = 2'd2;
		endcase
	end

	always_comb begin
		unique case (edge_sel)
			2'd0: begin
				pa = p0; pb = p1; qa = it_q.q0; qb = it_q.q1;
			end
			2'd1: begin
				pa = p1; pb = p2; qa = it_q.q1; qb = it_q.q2;
			end
			default: begin
				pa = p2; pb = p0; qa = it_q.q2; qb = it_q.q0;
			end
		endcase
	end

	always_comb begin
		if (step_q < 3'd2) begin
			if (it_q.front == step_q[0]) begin
				// back-facing near cap or front-facing far cap
				ta = it_q.front ? it_q.q2 : p2;
				tb = it_q.front ? it_q.q1 : p1;
				tc = it_q.front ? it_q.q0 : p0;
			end else begin
				ta = it_q.front ? p0 : it_q.q0;
				tb = it_q.front ? p1 : it_q.q1;
				tc = it_q.front ? p2 : it_q.q2;
			end
		end else if (it_q.front) begin
			ta = step_q[0] ? pa : qb;
			tb = step_q[0] ? qa : pb;
			tc = step_q[0] ? qb : pa;
		end else begin
			ta = step_q[0] ? qb : pa;
			tb = step_q[0] ? qa : pb;
			tc = step_q[0] ? pa : qb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load_ready) begin
				busy_q <= load_valid;
				step_q <= '0;
			end else if (fire) begin
				step_q <= step_q + 3'd1;
			end
			if (out_free) begin
				valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			it_q <= load_item;
		end
		if (fire) begin
			is_vertex_q <= it_q.is_vtx;
			last_q      <= at_last;
			if (it_q.is_vtx) begin
				slot_q  <= step_q[0] ? it_q.slot_far : SLOT_W'(it_q.vidx);
				out_x_q <= step_q[0] ? it_q.far_x : it_q.near_x;
				out_y_q <= step_q[0] ? it_q.far_y : it_q.near_y;
				out_z_q <= step_q[0] ? it_q.far_z : it_q.near_z;
				tri_a_q <= '0;
				tri_b_q <= '0;
				tri_c_q <= '0;
			end else begin
				slot_q  <= '0;
				out_x_q <= '0;
				out_y_q <= '0;
				out_z_q <= '0;
				tri_a_q <= ta;
				tri_b_q <= tb;
				tri_c_q <= tc;
			end
		end
	end

	assign result.valid     = valid_q;
	assign result.is_vertex = is_vertex_q;
	assign result.slot      = slot_q;
	assign result.out_x     = out_x_q;
	assign result.out_y     = out_y_q;
	assign result.out_z     = out_z_q;
	assign result.tri_a     = tri_a_q;
	assign result.tri_b     = tri_b_q;
	assign result.tri_c     = tri_c_q;
	assign result.last      = last_q;

endmodule

[hdl/shadow_volume_extrusion.sv]
// channel   dir  payload
// item      in   action, vertex_index, pos_x/y/z, corner_0..2, normal_x/y/z, open_mask
// result    out  is_vertex, slot, out_x/y/z, tri_a/b/c, last
// wr_*      in   register index and data, one write per cycle with wr_en
//
// Stage 1 registers the request and forms the normal products, saturated sums and
// extruded indices; stage 2 adds the products; the sequencer then sends one result
// per cycle from the output register. Requests pass the stage 1, stage 2, sequencer
// item and output registers in order. A vertex item gives 2 results, a triangle
// item 2 plus 2 per open edge (up to 8). Reset clears valid and config registers.
// A stalled result holds the sequencer; the stages behind it fill and then stall.
module shadow_volume_extrusion import sve_pkg::*; #(
	parameter int MAX_VERTS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [COORD_W-1:0]   wr_data,
	sve_item_if.sink             item,
	sve_result_if.source         result
);

	localparam slot_t VC_MAX = (MAX_VERTS >= (1 << SLOT_W)) ? {SLOT_W{1'b1}}
		: SLOT_W'(MAX_VERTS);

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic signed [COORD_W:0] s;
		begin
			s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
			if (s[COORD_W] != s[COORD_W-1]) begin
				sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
					: {1'b0, {(COORD_W-1){1'b1}}};
			end else begin
				sat_add = s[COORD_W-1:0];
			end
		end
	endfunction

	coord_t far_x_q, far_y_q, far_z_q;
	coord_t near_x_q, near_y_q, near_z_q;
	slot_t  vcount_q;
	slot_t  wr_count;

	// held already clamped, the only form in which it is used
	assign wr_count = (wr_data[SLOT_W-1:0] > VC_MAX) ? VC_MAX : wr_data[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_x_q  <= '0;
			far_y_q  <= '0;
			far_z_q  <= '0;
			near_x_q <= '0;
			near_y_q <= '0;
			near_z_q <= '0;
			vcount_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_FAR_X:        far_x_q  <= wr_data;
				REG_FAR_Y:        far_y_q  <= wr_data;
				REG_FAR_Z:        far_z_q  <= wr_data;
				REG_NEAR_X:       near_x_q <= wr_data;
				REG_NEAR_Y:       near_y_q <= wr_data;
				REG_NEAR_Z:       near_z_q <= wr_data;
				REG_VERTEX_COUNT: vcount_q <= wr_count;
				default: ;
			endcase
		end
	end

	// stage 1: request register
	logic              v_s1;
	logic              action_s1;
	vidx_t             vidx_s1;
	coord_t            pos_x_s1, pos_y_s1, pos_z_s1;
	vidx_t             c0_s1, c1_s1, c2_s1;
	norm_t             nrm_x_s1, nrm_y_s1, nrm_z_s1;
	logic [MASK_W-1:0] mask_s1;

	// stage 2
	logic                     v_s2;
	item_t                    it_s2;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2, prod_z_s2;

	logic                     s1_free, s2_free, emit_ready;
	logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
	logic signed [DOT_W-1:0]  dot;
	item_t                    it_s1;
	item_t                    it_emit;

	assign s2_free    = !v_s2 || emit_ready;
	assign s1_free    = !v_s1 || s2_free;
	assign item.ready = s1_free;

	assign prod_x = PROD_W'(nrm_x_s1) * PROD_W'(far_x_q);
	assign prod_y = PROD_W'(nrm_y_s1) * PROD_W'(far_y_q);
	assign prod_z = PROD_W'(nrm_z_s1) * PROD_W'(far_z_q);

	always_comb begin
		it_s1.is_vtx    = !action_s1;
		it_s1.front     = 1'b0;
		it_s1.open_mask = mask_s1;
		it_s1.vidx      = vidx_s1;
		it_s1.slot_far  = SLOT_W'(vidx_s1) + vcount_q;
		it_s1.near_x    = sat_add(pos_x_s1, near_x_q);
		it_s1.near_y    = sat_add(pos_y_s1, near_y_q);
		it_s1.near_z    = sat_add(pos_z_s1, near_z_q);
		it_s1.far_x     = sat_add(pos_x_s1, far_x_q);
		it_s1.far_y     = sat_add(pos_y_s1, far_y_q);
		it_s1.far_z     = sat_add(pos_z_s1, far_z_q);
		it_s1.p0        = c0_s1;
		it_s1.p1        = c1_s1;
		it_s1.p2        = c2_s1;
		it_s1.q0        = SLOT_W'(c0_s1) + vcount_q;
		it_s1.q1        = SLOT_W'(c1_s1) + vcount_q;
		it_s1.q2        = SLOT_W'(c2_s1) + vcount_q;
	end

	// only the sign of the dot product is kept
	assign dot = DOT_W'(prod_x_s2) + DOT_W'(prod_y_s2) + DOT_W'(prod_z_s2);

	always_comb begin
		it_emit       = it_s2;
		it_emit.front = dot[DOT_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= item.valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && s1_free) begin
			action_s1 <= item.action;
			vidx_s1   <= item.vertex_index;
			pos_x_s1  <= item.pos_x;
			pos_y_s1  <= item.pos_y;
			pos_z_s1  <= item.pos_z;
			c0_s1     <= item.corner_0;
			c1_s1     <= item.corner_1;
			c2_s1     <= item.corner_2;
			nrm_x_s1  <= item.normal_x;
			nrm_y_s1  <= item.normal_y;
			nrm_z_s1  <= item.normal_z;
			mask_s1   <= item.open_mask;
		end
		if (v_s1 && s2_free) begin
			it_s2     <= it_s1;
			prod_x_s2 <= prod_x;
			prod_y_s2 <= prod_y;
			prod_z_s2 <= prod_z;
		end
	end

	sve_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s2),
		.load_ready (emit_ready),
		.load_item  (it_emit),
		.result     (result)
	);

endmodule

[tb/sve_extrusion_scoreboard.sv]
`timescale 1ns / 1ps

module sve_extrusion_scoreboard import sve_pkg::*; #(
	parameter int MAX_VERTS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [COORD_W-1:0]   wr_data,
	sve_item_if                  item,
	sve_result_if                result,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic   is_vertex;
		slot_t  slot;
		coord_t x;
		coord_t y;
		coord_t z;
		slot_t  a;
		slot_t  b;
		slot_t  c;
		logic   last;
	} vol_result_t;

	coord_t      far_off [3];
	coord_t      near_off [3];
	slot_t       vcount;
	vol_result_t volume_q [$];
	slot_t       tri_seq [$];
	int          bad = 0;

	assign mismatches  = bad;
	assign outstanding = volume_q.size();

	function automatic coord_t sat_add(coord_t a, coord_t b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647)
			s = 64'sd2147483647;
		if (s < -64'sd2147483648)
			s = -64'sd2147483648;
		return s[COORD_W-1:0];
	endfunction

	function automatic void add_tri(slot_t a, slot_t b, slot_t c);
		tri_seq.push_back(a);
		tri_seq.push_back(b);
		tri_seq.push_back(c);
	endfunction

	// expected volume vertices / triangles for the request on the item channel
	function automatic void extrude_item();
		slot_t       base;
		slot_t       p [3];
		slot_t       q [3];
		longint      dot;
		vol_result_t r;
		int          k;
		base = (vcount > MAX_VERTS) ? slot_t'(MAX_VERTS) : vcount;
		if (!item.action) begin
			r = '0;
			r.is_vertex = 1'b1;
			r.slot = {1'b0, item.vertex_index};
			r.x = sat_add(item.pos_x, near_off[0]);
			r.y = sat_add(item.pos_y, near_off[1]);
			r.z = sat_add(item.pos_z, near_off[2]);
			volume_q.push_back(r);
			r.slot = {1'b0, item.vertex_index} + base;
			r.x = sat_add(item.pos_x, far_off[0]);
			r.y = sat_add(item.pos_y, far_off[1]);
			r.z = sat_add(item.pos_z, far_off[2]);
			r.last = 1'b1;
			volume_q.push_back(r);
		end else begin
			tri_seq.delete();
			p[0] = {1'b0, item.corner_0};
			p[1] = {1'b0, item.corner_1};
			p[2] = {1'b0, item.corner_2};
			for (k = 0; k < 3; k++)
				q[k] = p[k] + base;
			dot = longint'(item.normal_x) * longint'(far_off[0])
				+ longint'(item.normal_y) * longint'(far_off[1])
				+ longint'(item.normal_z) * longint'(far_off[2]);
			// negative dot: triangle faces the light
			if (dot < 0) begin
				add_tri(p[0], p[1], p[2]);
				add_tri(q[2], q[1], q[0]);
				if (item.open_mask[0]) begin
					add_tri(q[1], p[1], p[0]);
					add_tri(p[0], q[0], q[1]);
				end
				if (item.open_mask[1]) begin
					add_tri(q[2], p[2], p[1]);
					add_tri(p[1], q[1], q[2]);
				end
				if (item.open_mask[2]) begin
					add_tri(q[0], p[0], p[2]);
					add_tri(p[2], q[2], q[0]);
				end
			end else begin
				add_tri(p[2], p[1], p[0]);
				add_tri(q[0], q[1], q[2]);
				if (item.open_mask[0]) begin
					add_tri(p[0], p[1], q[1]);
					add_tri(q[1], q[0], p[0]);
				end
				if (item.open_mask[1]) begin
					add_tri(p[1], p[2], q[2]);
					add_tri(q[2], q[1], p[1]);
				end
				if (item.open_mask[2]) begin
					add_tri(p[2], p[0], q[0]);
					add_tri(q[0], q[2], p[2]);
				end
			end
			for (k = 0; k < tri_seq.size(); k += 3) begin
				r = '0;
				r.a = tri_seq[k];
				r.b = tri_seq[k+1];
				r.c = tri_seq[k+2];
				r.last = (k + 3 == tri_seq.size());
				volume_q.push_back(r);
			end
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			bad++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vol_result_t want;
		if (!arst_n) begin
			far_off  = '{3{'0}};
			near_off = '{3{'0}};
			vcount   = '0;
			volume_q.delete();
		end else begin
			if (item.valid && item.ready)
				extrude_item();
			if (result.valid && result.ready) begin
				if (volume_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual slot 0x%0h tri %0h/%0h/%0h",
						$time, result.slot, result.tri_a, result.tri_b, result.tri_c);
					bad++;
				end else begin
					want = volume_q.pop_front();
					check_field("is_vertex", want.is_vertex, result.is_vertex);
					check_field("slot", want.slot, result.slot);
					check_field("out_x", want.x, result.out_x);
					check_field("out_y", want.y, result.out_y);
					check_field("out_z", want.z, result.out_z);
					check_field("tri_a", want.a, result.tri_a);
					check_field("tri_b", want.b, result.tri_b);
					check_field("tri_c", want.c, result.tri_c);
					check_field("last", want.last, result.last);
				end
			end
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_FAR_X:        far_off[0]  = wr_data;
					REG_FAR_Y:        far_off[1]  = wr_data;
					REG_FAR_Z:        far_off[2]  = wr_data;
					REG_NEAR_X:       near_off[0] = wr_data;
					REG_NEAR_Y:       near_off[1] = wr_data;
					REG_NEAR_Z:       near_off[2] = wr_data;
					REG_VERTEX_COUNT: vcount      = wr_data[SLOT_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/shadow_volume_extrusion_tb.sv]
`timescale 1ns / 1ps

module shadow_volume_extrusion_tb;
	import sve_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 44;

	typedef struct packed {
		logic              action;
		vidx_t             vidx;
		coord_t            pos_x;
		coord_t            pos_y;
		coord_t            pos_z;
		vidx_t             c0;
		vidx_t             c1;
		vidx_t             c2;
		norm_t             nx;
		norm_t             ny;
		norm_t             nz;
		logic [MASK_W-1:0] mask;
	} mesh_req_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [COORD_W-1:0]   wr_data;
	int                   mismatches;
	int                   outstanding;
	int                   stall_cycles = 0;
	int                   hold_asked = 0;
	bit                   quiet = 1'b0;

	sve_item_if   item_ch ();
	sve_result_if result_ch ();

	shadow_volume_extrusion u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	sve_extrusion_scoreboard u_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic mesh_req_t vertex_req(int idx, coord_t x, coord_t y, coord_t z);
		mesh_req_t r;
		r = '0;
		r.vidx  = vidx_t'(idx);
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		return r;
	endfunction

	function automatic mesh_req_t tri_req(int c0, int c1, int c2,
			int nx, int ny, int nz, logic [MASK_W-1:0] mask);
		mesh_req_t r;
		r = '0;
		r.action = 1'b1;
		r.c0 = vidx_t'(c0);
		r.c1 = vidx_t'(c1);
		r.c2 = vidx_t'(c2);
		r.nx = norm_t'(nx);
		r.ny = norm_t'(ny);
		r.nz = norm_t'(nz);
		r.mask = mask;
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return coord_t'($urandom_range(262144)) - 32'sd131072;
			default: return $urandom();
		endcase
	endfunction

	function automatic mesh_req_t rand_req();
		mesh_req_t r;
		r.action = 1'($urandom_range(1));
		r.vidx   = vidx_t'($urandom());
		r.pos_x  = rand_coord();
		r.pos_y  = rand_coord();
		r.pos_z  = rand_coord();
		r.c0     = vidx_t'($urandom());
		r.c1     = vidx_t'($urandom());
		r.c2     = vidx_t'($urandom());
		r.nx     = norm_t'($urandom());
		r.ny     = norm_t'($urandom());
		r.nz     = norm_t'($urandom());
		// a zero normal lands exactly on the dot == 0 boundary
		if ($urandom_range(9) == 0) begin
			r.nx = '0;
			r.ny = '0;
			r.nz = '0;
		end
		r.mask = MASK_W'($urandom_range(7));
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_request(mesh_req_t r);
		while (!quiet && $urandom_range(99) < 13) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.action       <= r.action;
		item_ch.vertex_index <= r.vidx;
		item_ch.pos_x        <= r.pos_x;
		item_ch.pos_y        <= r.pos_y;
		item_ch.pos_z        <= r.pos_z;
		item_ch.corner_0     <= r.c0;
		item_ch.corner_1     <= r.c1;
		item_ch.corner_2     <= r.c2;
		item_ch.normal_x     <= r.nx;
		item_ch.normal_y     <= r.ny;
		item_ch.normal_z     <= r.nz;
		item_ch.open_mask    <= r.mask;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_requests(int n);
		repeat (n)
			push_request(rand_req());
	endtask

	task automatic put_reg(reg_idx_t idx, logic [COORD_W-1:0] data);
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
	endtask

	task automatic load_config(coord_t fx, coord_t fy, coord_t fz,
			coord_t nx, coord_t ny, coord_t nz, logic [COORD_W-1:0] vc);
		wr_en <= 1'b1;
		put_reg(REG_FAR_X, fx);
		put_reg(REG_FAR_Y, fy);
		put_reg(REG_FAR_Z, fz);
		put_reg(REG_NEAR_X, nx);
		put_reg(REG_NEAR_Y, ny);
		put_reg(REG_NEAR_Z, nz);
		put_reg(REG_VERTEX_COUNT, vc);
		wr_en <= 1'b0;
	endtask

	// stop sending and let the block empty out before touching registers
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left   = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= quiet || ($urandom_range(99) >= 13);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("shadow_volume_extrusion regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n               <= 1'b0;
		wr_en                <= 1'b0;
		wr_index             <= REG_FAR_X;
		wr_data              <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.action       <= 1'b0;
		item_ch.vertex_index <= '0;
		item_ch.pos_x        <= '0;
		item_ch.pos_y        <= '0;
		item_ch.pos_z        <= '0;
		item_ch.corner_0     <= '0;
		item_ch.corner_1     <= '0;
		item_ch.corner_2     <= '0;
		item_ch.normal_x     <= '0;
		item_ch.normal_y     <= '0;
		item_ch.normal_z     <= '0;
		item_ch.open_mask    <= '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// far = (1.0, -2.0, 0.5), near about (0.1, -0.2, 0.05)
		load_config(32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000,
			32'h0000_1999, 32'hFFFF_CCCD, 32'h0000_0CCD, 100);
		push_request(vertex_req(0, 0, 0, 0));
		push_request(vertex_req(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		push_request(vertex_req(2048, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		push_request(vertex_req(4095, 32'h8000_0000, 32'h7FFF_FFFF, 0));
		push_request(tri_req(0, 1, 2, 16384, 0, 0, 3'd0));
		push_request(tri_req(4095, 2048, 0, -16384, 0, 0, 3'd7));
		push_request(tri_req(3, 4, 5, 0, 0, 0, 3'd7));
		// nonzero normal exactly perpendicular to the far offset
		push_request(tri_req(6, 7, 8, 2, 1, 0, 3'd5));
		push_request(tri_req(10, 11, 12, 0, -32768, 0, 3'd1));
		push_request(tri_req(13, 14, 15, 0, 32767, 0, 3'd2));
		push_request(tri_req(20, 21, 22, -32768, -32768, -32768, 3'd3));
		push_request(tri_req(23, 24, 25, 32767, 32767, 32767, 3'd4));
		push_request(tri_req(4095, 4095, 4095, -16384, 0, 0, 3'd6));
		push_request(tri_req(1, 2, 3, 0, 0, 16384, 3'd6));
		drain();

		load_config($urandom(), $urandom(), $urandom(),
			coord_t'($urandom_range(13108)) - 32'sd6554,
			coord_t'($urandom_range(13108)) - 32'sd6554,
			coord_t'($urandom_range(13108)) - 32'sd6554,
			$urandom_range(4096));
		random_requests(10);
		// result side holds off while requests keep coming
		hold_asked++;
		random_requests(PHASE_ITEMS - 10);
		drain();

		load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8191);
		quiet = 1'b1;
		random_requests(PHASE_ITEMS);
		quiet = 1'b0;
		drain();

		load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		random_requests(PHASE_ITEMS);
		drain();

		// zero far offset: every triangle takes the back-facing path
		load_config(0, 0, 0, 0, 0, 0, 4096);
		random_requests(PHASE_ITEMS);
		drain();

		load_config($urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), 4097);
		random_requests(PHASE_ITEMS);
		drain();

		// upper data bits above the count width must be dropped
		load_config($urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom());
		random_requests(PHASE_ITEMS);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("shadow_volume_extrusion regression: pass");
		else
			$display("shadow_volume_extrusion regression: fail");
		$finish;
	end

endmodule

[sim.f]
hdl/sve_pkg.sv
hdl/sve_item_if.sv
hdl/sve_result_if.sv
hdl/sve_emit.sv
hdl/shadow_volume_extrusion.sv
tb/sve_extrusion_scoreboard.sv
tb/shadow_volume_extrusion_tb.sv
